@@ rtl/clsd_pkg.sv @@
package clsd_pkg;

  localparam int unsigned FRAME_W  = 23;
  localparam int unsigned DIGIT_W  = 11;
  localparam int unsigned PIN_W    = 6;
  localparam int unsigned SCAN_W   = 5;
  localparam int unsigned BRIGHT_W = 7;
  localparam int unsigned NUM_W    = 8;
  localparam int unsigned PAIR_CNT = 30;

  localparam int unsigned NUM_LEDS_DEF   = 23;
  localparam int unsigned SLOT_TICKS_DEF = 100;

  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX  = 7'd99;
  localparam logic [FRAME_W-1:0]  FRAME_RESET = 23'h6FEF80;
  localparam int unsigned         ACT_BIT     = 22;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SHOW  = 2'd1,
    REQ_FRAME = 2'd2,
    REQ_ACT   = 2'd3
  } req_e;

  // Segment patterns of the decimal digits.
  localparam logic [DIGIT_W-1:0] DIGIT_SEG [10] = '{
    11'h7DF, 11'h780, 11'h5FD, 11'h7F9, 11'h7A3,
    11'h6DB, 11'h6FF, 11'h791, 11'h7FF, 11'h7FB
  };

  // Pin pair of each LED, written in octal as {high pin, low pin}.
  localparam logic [5:0] PIN_PAIR [PAIR_CNT] = '{
    6'o01, 6'o02, 6'o03, 6'o04, 6'o05,
    6'o10, 6'o12, 6'o13, 6'o14, 6'o15,
    6'o20, 6'o21, 6'o23, 6'o24, 6'o25,
    6'o30, 6'o31, 6'o32, 6'o34, 6'o35,
    6'o40, 6'o41, 6'o42, 6'o43, 6'o45,
    6'o50, 6'o51, 6'o52, 6'o53, 6'o54
  };

  typedef struct packed {
    logic [PIN_W-1:0] en;
    logic [PIN_W-1:0] lvl;
  } pin_drive_t;

endpackage

@@ rtl/clsd_num_frame.sv @@
module clsd_num_frame
  import clsd_pkg::*;
(
  input  logic [NUM_W-1:0]   number_i,
  output logic [FRAME_W-1:0] frame_o
);

  logic [15:0]        prod;
  logic [4:0]         tens;
  logic [NUM_W-1:0]   ones_full;
  logic [3:0]         ones;
  logic [DIGIT_W-1:0] tens_seg;

  // Multiplying by 205/2048 gives the exact quotient by ten for every 8-bit value.
  assign prod      = 16'(number_i) * 16'd205;
  assign tens      = prod[15:11];
  assign ones_full = number_i - 8'(8'(tens) * 8'd10);
  assign ones      = ones_full[3:0];

  // A tens digit above nine has no pattern and stays blank.
  assign tens_seg = (tens <= 5'd9) ? DIGIT_SEG[tens[3:0]] : '0;

  assign frame_o = {1'b0, DIGIT_SEG[ones], tens_seg};

endmodule

@@ rtl/clsd_pin_decode.sv @@
module clsd_pin_decode
  import clsd_pkg::*;
(
  input  logic [FRAME_W-1:0] frame_i,
  input  logic [SCAN_W-1:0]  scan_i,
  input  logic               window_i,
  output pin_drive_t         drive_o
);

  logic               in_frame;
  logic [SCAN_W-1:0]  idx;
  logic [FRAME_W-1:0] shifted;
  logic [2:0]         hi;
  logic [2:0]         lo;
  logic               lit;

  // An LED index past the frame has no bit and stays dark.
  assign in_frame = (scan_i < SCAN_W'(FRAME_W));
  assign idx      = in_frame ? scan_i : '0;
  assign shifted  = frame_i >> idx;
  assign lit      = window_i && in_frame && shifted[0];
  assign hi       = PIN_PAIR[idx][5:3];
  assign lo       = PIN_PAIR[idx][2:0];

  always_comb begin
    drive_o = '0;
    if (lit) begin
      drive_o.en  = (PIN_W'(1) << hi) | (PIN_W'(1) << lo);
      drive_o.lvl = PIN_W'(1) << hi;
    end
  end

endmodule

@@ rtl/charlieplex_led_scan_driver.sv @@
// Charlieplexed LED scan driver, six pins and up to twenty-three LEDs, one per frame bit.
// The result of an item is registered and on the master side in the cycle after its transaction.
// One item per cycle unless the master stalls; the single output register frees as taken.
// Reset (rst_ni low, asynchronous) empties the output register, sets brightness to 99,
// the frame to show 12 with activity, the scan and slot counter to zero, display on.
module charlieplex_led_scan_driver
  import clsd_pkg::*;
#(
  parameter int unsigned NUM_LEDS   = NUM_LEDS_DEF,
  parameter int unsigned SLOT_TICKS = SLOT_TICKS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          brightness_we_i,
  input  logic [6:0]    brightness_i,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // number [7:0], frame_value [30:8], activity [31]
  input  logic [31:0]   s_axis_tdata_i,
  // req_type [1:0]
  input  logic [1:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // pin_enable [5:0], pin_level [11:6], strobe_res [12], scan_position [17:13], zeros above
  output logic [23:0]   m_axis_tdata_o
);

  localparam int unsigned CntW = $clog2(SLOT_TICKS);
  localparam int unsigned CmpW = (CntW > BRIGHT_W) ? CntW : BRIGHT_W;

  logic [BRIGHT_W-1:0] brightness_q;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic [SCAN_W-1:0]   scan_q, scan_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                enabled_q, enabled_d;

  logic                out_valid_q;
  logic [23:0]         out_data_q;

  logic                accept;
  req_e                req;
  logic [NUM_W-1:0]    number;
  logic [FRAME_W-1:0]  frame_value;
  logic                activity;
  logic [FRAME_W-1:0]  num_frame;
  logic                window;
  pin_drive_t          drive;

  assign req         = req_e'(s_axis_tuser_i);
  assign number      = s_axis_tdata_i[7:0];
  assign frame_value = s_axis_tdata_i[30:8];
  assign activity    = s_axis_tdata_i[31];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  clsd_num_frame u_num_frame (
    .number_i (number),
    .frame_o  (num_frame)
  );

  always_comb begin
    frame_d   = frame_q;
    scan_d    = scan_q;
    cnt_d     = cnt_q;
    enabled_d = enabled_q;
    case (req)
      REQ_TICK: begin
        if (cnt_q == CntW'(SLOT_TICKS - 1)) begin
          cnt_d = '0;
          // The scan holds while the display is off.
          if (enabled_q) begin
            scan_d = (scan_q == SCAN_W'(NUM_LEDS - 1)) ? '0 : scan_q + SCAN_W'(1);
          end
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      REQ_SHOW: begin
        frame_d   = num_frame;
        enabled_d = (num_frame != '0);
      end
      REQ_FRAME: begin
        frame_d = frame_value;
      end
      REQ_ACT: begin
        frame_d[ACT_BIT] = activity;
      end
      default: begin
        frame_d = frame_q;
      end
    endcase
  end

  assign window = enabled_d && (CmpW'(cnt_d) < CmpW'(brightness_q));

  clsd_pin_decode u_pin_decode (
    .frame_i  (frame_d),
    .scan_i   (scan_d),
    .window_i (window),
    .drive_o  (drive)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= BRIGHT_MAX;
    end else if (brightness_we_i) begin
      brightness_q <= (brightness_i > BRIGHT_MAX) ? BRIGHT_MAX : brightness_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q   <= FRAME_RESET;
      scan_q    <= '0;
      cnt_q     <= '0;
      enabled_q <= 1'b1;
    end else if (accept) begin
      frame_q   <= frame_d;
      scan_q    <= scan_d;
      cnt_q     <= cnt_d;
      enabled_q <= enabled_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {6'b0, scan_d, window, drive.lvl, drive.en};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // A driven level only ever appears on an enabled pin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o[11:6] & ~m_axis_tdata_o[5:0]) == 6'b0))
    else $error("pin level set on a released pin");

  // A lit LED drives exactly two pins, one of them high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[5:0] != 6'b0)) |->
      ($countones(m_axis_tdata_o[5:0]) == 2 && $countones(m_axis_tdata_o[11:6]) == 1))
    else $error("lit LED does not drive one pin pair");

  // Pins are driven only inside the strobe window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[12]) |-> (m_axis_tdata_o[5:0] == 6'b0))
    else $error("pins driven outside the lit window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (brightness_q <= BRIGHT_MAX) && (scan_q < SCAN_W'(NUM_LEDS)))
    else $error("brightness or scan position out of range");

  // The scan moves only on a tick that closes a slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !(req == REQ_TICK && cnt_q == CntW'(SLOT_TICKS - 1))) |=> $stable(scan_q))
    else $error("scan moved without a slot wrap");
`endif

endmodule
